// ===== rtl/core/sdd_pkg.sv =====
// Package for the card deck block: slot geometry, field widths, operation codes
// and the structs passed between the deck submodules.
// No dependencies.
package sdd_pkg;

    localparam int DECK_SLOTS = 64;
    localparam int SLOT_W     = $clog2(DECK_SLOTS);
    localparam int LPOS_W     = $clog2(DECK_SLOTS + 1);
    localparam int DVS_W      = SLOT_W + 1;
    localparam int CARD_W     = 10;
    localparam int RND_W      = 31;
    localparam int RCNT_W     = $clog2(RND_W);
    localparam int OP_W       = 2;

    // Draw search: slots in groups of eight; the first full group is picked, then the first full slot in it
    localparam int SRCH_GRP   = 8;
    localparam int SRCH_BIT_W = 3;
    localparam int SRCH_NGRP  = (DECK_SLOTS + SRCH_GRP - 1) / SRCH_GRP;
    localparam int SRCH_GRP_W = (SRCH_NGRP > 1) ? $clog2(SRCH_NGRP) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DECK_SLOTS - 1);
    localparam logic [LPOS_W-1:0] LOAD_END  = LPOS_W'(DECK_SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_SHUFFLE = 2'd2,
        OP_DRAW    = 2'd3
    } t_op;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [CARD_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_srch_res;

endpackage

// ===== rtl/core/shuffle_and_draw_deck.sv =====
// Card deck engine: a 64-slot store of card indices with a full mark per slot,
// loaded in order, shuffled in place and drawn from the lowest full slot.
// Depends on sdd_pkg, sdd_card_mem, sdd_mod_unit and sdd_draw_search.
//
// One beat in, one beat out, one operation at a time. The operation code rides
// in s_axis_tuser; card index and random word ride in s_axis_tdata. Clear and
// load go from the accept straight to the result. A draw runs through the
// accept, a three-stage first-full-slot search, one card memory read, then the
// result. A shuffle step runs through the accept, the bit-serial remainder of
// the 31-bit random word by i+1, the read-read-write-write swap through the
// card memory, then the result. The result beat is held in an output register,
// so the next operation is accepted while the previous result still waits;
// completion stalls only if that register is still occupied. Full marks live
// in flip-flops and clear at once on reset or a clear operation, so no
// clearing pass is needed. Card indices of never-loaded slots are undefined,
// but they are never returned because a draw only takes full slots.
module shuffle_and_draw_deck
    import sdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [9:0] card_index, [40:10] random_word, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] drawn_card, rest zero
    output logic [2:0]  m_axis_tuser    // [0] card_found, [1] shuffle_done, [2] load_dropped
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_RDI  = 8'b0000_0100,
        ST_RDJ  = 8'b0000_1000,
        ST_WRI  = 8'b0001_0000,
        ST_WRJ  = 8'b0010_0000,
        ST_SRCH = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic                  s_acc;
    t_op                   in_op;
    logic [CARD_W-1:0]     in_card;
    logic [RND_W-1:0]      in_rnd;

    logic [DECK_SLOTS-1:0] r_full;
    logic [DECK_SLOTS-1:0] n_full;
    logic [LPOS_W-1:0]     r_load_pos;
    logic [SLOT_W-1:0]     r_shuf_pos;
    logic [SLOT_W-1:0]     r_i;
    logic [SLOT_W-1:0]     r_j;
    logic [CARD_W-1:0]     r_card_i;
    logic                  r_draw_rd;
    logic [SLOT_W-1:0]     i_eff;
    logic [SLOT_W-1:0]     i_next;

    logic [CARD_W-1:0]     r_res_card;
    logic                  r_res_found;
    logic                  r_res_done;
    logic                  r_res_drop;

    logic                  r_m_valid;
    logic [CARD_W-1:0]     r_m_card;
    logic [2:0]            r_m_flags;
    logic                  out_load;

    t_mem_wr               mem_wr;
    logic [SLOT_W-1:0]     mem_rd_addr;
    logic [CARD_W-1:0]     mem_rd_data;

    logic                  mod_start;
    logic                  mod_done;
    logic [SLOT_W-1:0]     mod_rem;

    logic                  srch_start;
    t_srch_res             srch_res;

    // Unpack the input beat
    assign in_op   = t_op'(s_axis_tuser);
    assign in_card = s_axis_tdata[CARD_W-1:0];
    assign in_rnd  = s_axis_tdata[CARD_W +: RND_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);

    // Shuffle index: fall back to the last slot if it ever sits out of range
    assign i_eff  = (r_shuf_pos == '0 || r_shuf_pos > LAST_SLOT) ? LAST_SLOT : r_shuf_pos;
    assign i_next = r_i - 1'b1;

    assign mod_start  = s_acc && (in_op == OP_SHUFFLE);
    assign srch_start = s_acc && (in_op == OP_DRAW);

    // Card memory port selection: load writes on accept, the swap writes i then j
    always_comb begin
        mem_wr      = '0;
        mem_rd_addr = r_i;
        unique case (r_state)
            ST_IDLE: begin
                mem_wr.en   = s_acc && (in_op == OP_LOAD) && (r_load_pos < LOAD_END);
                mem_wr.addr = r_load_pos[SLOT_W-1:0];
                mem_wr.data = in_card;
            end
            ST_RDI: begin
                mem_rd_addr = r_i;
            end
            ST_RDJ: begin
                mem_rd_addr = r_j;
            end
            ST_WRI: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_i;
                mem_wr.data = mem_rd_data;
            end
            ST_WRJ: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_j;
                mem_wr.data = r_card_i;
            end
            ST_SRCH: begin
                mem_rd_addr = srch_res.idx;
            end
            default: begin
                mem_rd_addr = r_i;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (in_op)
                        OP_SHUFFLE: n_state = ST_DIV;
                        OP_DRAW:    n_state = ST_SRCH;
                        default:    n_state = ST_OUT;
                    endcase
                end
            end
            ST_DIV:  if (mod_done) n_state = ST_RDI;
            ST_RDI:  n_state = ST_RDJ;
            ST_RDJ:  n_state = ST_WRI;
            ST_WRI:  n_state = ST_WRJ;
            ST_WRJ:  n_state = ST_OUT;
            ST_SRCH: if (srch_res.valid) n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Next full marks: clear, load, swap and draw never fall in the same cycle
    always_comb begin
        n_full = r_full;
        if (s_acc && in_op == OP_CLEAR) begin
            n_full = '0;
        end
        if (mem_wr.en && r_state == ST_IDLE) begin
            n_full[mem_wr.addr] = 1'b1;
        end
        // Swap the full marks together with the cards
        if (r_state == ST_WRI) begin
            n_full[r_i] = r_full[r_j];
            n_full[r_j] = r_full[r_i];
        end
        // Empty the drawn slot once the search reports it
        if (r_state == ST_SRCH && srch_res.valid && srch_res.found) begin
            n_full[srch_res.idx] = 1'b0;
        end
    end

    // Control state: FSM, full marks, load and shuffle positions, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_full     <= '0;
            r_load_pos <= '0;
            r_shuf_pos <= LAST_SLOT;
            r_m_valid  <= 1'b0;
            r_draw_rd  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_full    <= n_full;
            r_draw_rd <= 1'b0;
            if (s_acc && in_op == OP_CLEAR) begin
                r_load_pos <= '0;
                r_shuf_pos <= LAST_SLOT;
            end
            if (mem_wr.en && r_state == ST_IDLE) begin
                r_load_pos <= r_load_pos + 1'b1;
            end
            if (r_state == ST_WRJ) begin
                r_shuf_pos <= (i_next == '0) ? LAST_SLOT : i_next;
            end
            // Fetch the drawn card once the search reports it
            if (r_state == ST_SRCH && srch_res.valid && srch_res.found) begin
                r_draw_rd <= 1'b1;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload: swap operands and the result under construction
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_i         <= i_eff;
            r_res_card  <= '0;
            r_res_found <= 1'b0;
            r_res_done  <= 1'b0;
            r_res_drop  <= (in_op == OP_LOAD) && (r_load_pos >= LOAD_END);
        end
        if (r_state == ST_DIV && mod_done) begin
            r_j <= mod_rem;
        end
        if (r_state == ST_RDJ) begin
            r_card_i <= mem_rd_data;
        end
        if (r_state == ST_WRJ) begin
            r_res_done <= (i_next == '0);
        end
        if (r_state == ST_SRCH && srch_res.valid) begin
            r_res_found <= srch_res.found;
        end
        // Drawn card arrives in the cycle after the search reports it, while in ST_OUT
        if (r_draw_rd) begin
            r_res_card <= mem_rd_data;
        end
        if (out_load) begin
            r_m_card  <= r_draw_rd ? mem_rd_data : r_res_card;
            r_m_flags <= {r_res_drop, r_res_done, r_res_found};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(16 - CARD_W){1'b0}}, r_m_card};
    assign m_axis_tuser  = r_m_flags;

    sdd_card_mem u_card_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    sdd_mod_unit u_mod_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (in_rnd),
        .i_divisor  (DVS_W'({1'b0, i_eff}) + 1'b1),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    sdd_draw_search u_draw_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_full  (r_full),
        .o_res   (srch_res)
    );

endmodule

// ===== rtl/core/sdd_card_mem.sv =====
// Card index store: one write port, one read port, registered read data.
// Depends on sdd_pkg.
module sdd_card_mem
    import sdd_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output logic [CARD_W-1:0] o_rd_data
);

    logic [CARD_W-1:0] r_mem [DECK_SLOTS];
    logic [CARD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/sdd_mod_unit.sv =====
// Iterative remainder unit: random word modulo a small divisor, one
// dividend bit per cycle (restoring). Depends on sdd_pkg.
module sdd_mod_unit
    import sdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RND_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [RCNT_W-1:0] r_cnt;
    logic [RND_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W:0]    shifted;
    logic [DVS_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[RND_W-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = DVS_W'(shifted - {1'b0, r_dvs});
        end else begin
            n_rem = DVS_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= RCNT_W'(RND_W - 1);
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[SLOT_W-1:0];

endmodule

// ===== rtl/core/sdd_draw_search.sv =====
// First-full-slot search over the full marks, three registered stages:
// group any-bits, first group, first slot in that group. Depends on sdd_pkg.
module sdd_draw_search
    import sdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DECK_SLOTS-1:0] i_full,
    output t_srch_res             o_res
);

    logic [SRCH_NGRP*SRCH_GRP-1:0] pad;
    logic [SRCH_NGRP-1:0]          grp_any;
    logic [SRCH_NGRP-1:0]          r_grp_any;
    logic [SRCH_GRP_W-1:0]         first_grp;
    logic [SRCH_GRP_W-1:0]         r_grp;
    logic                          r_any;
    logic [SRCH_GRP-1:0]           grp_bits;
    logic [SRCH_BIT_W-1:0]         first_bit;
    logic [2:0]                    r_stage;
    logic                          r_found;
    logic [SLOT_W-1:0]             r_idx;

    always_comb begin
        pad = '0;
        pad[DECK_SLOTS-1:0] = i_full;
        for (int g = 0; g < SRCH_NGRP; g++) begin
            grp_any[g] = |pad[g*SRCH_GRP +: SRCH_GRP];
        end
        first_grp = '0;
        for (int g = SRCH_NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                first_grp = SRCH_GRP_W'(g);
            end
        end
        grp_bits  = pad[r_grp*SRCH_GRP +: SRCH_GRP];
        first_bit = '0;
        for (int b = SRCH_GRP - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                first_bit = SRCH_BIT_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= grp_any;
        r_grp     <= first_grp;
        r_any     <= |r_grp_any;
        r_found   <= r_any;
        r_idx     <= SLOT_W'({r_grp, first_bit});
    end

    assign o_res.valid = r_stage[2];
    assign o_res.found = r_found;
    assign o_res.idx   = r_idx;

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for shuffle_and_draw_deck: a table of directed beats, then random
// clear/load/shuffle/draw episodes, each result compared against an in-bench deck predictor.
// Depends on sdd_pkg and the shuffle_and_draw_deck RTL.
module testbench;
    import sdd_pkg::*;

    typedef struct packed {
        logic [CARD_W-1:0] card;
        logic              found;
        logic              done;
        logic              dropped;
    } deck_result_t;

    // One directed row: op, card, random word, repeat count, result typed in, typed result.
    // Repeated rows advance card and random word by the repeat index.
    typedef struct packed {
        t_op               op;
        logic [CARD_W-1:0] card;
        logic [RND_W-1:0]  rnd;
        logic [7:0]        reps;
        logic              typed;
        deck_result_t      want;
    } deck_row_t;

    localparam deck_result_t NONE = '{10'd0, 1'b0, 1'b0, 1'b0};
    localparam int           NUM_ROWS = 23;
    localparam int           RANDOM_ITEMS = 1000;

    localparam deck_row_t DIRECTED [NUM_ROWS] = '{
        '{OP_DRAW,    10'd0,    31'd0,          8'd1,  1'b1, NONE},       // empty after reset
        '{OP_CLEAR,   10'd0,    31'd0,          8'd1,  1'b1, NONE},
        '{OP_LOAD,    10'd1023, 31'd0,          8'd1,  1'b1, NONE},
        '{OP_LOAD,    10'd0,    31'h7FFFFFFF,   8'd1,  1'b1, NONE},
        '{OP_LOAD,    10'd100,  31'd0,          8'd62, 1'b0, NONE},       // fill every slot
        '{OP_LOAD,    10'd777,  31'd0,          8'd1,  1'b1, '{10'd0, 1'b0, 1'b0, 1'b1}},
        '{OP_DRAW,    10'd0,    31'd0,          8'd1,  1'b1, '{10'd1023, 1'b1, 1'b0, 1'b0}},
        '{OP_SHUFFLE, 10'd0,    31'h7FFFFFFF,   8'd1,  1'b0, NONE},
        '{OP_SHUFFLE, 10'd0,    31'd0,          8'd1,  1'b0, NONE},
        '{OP_SHUFFLE, 10'h3FF,  31'd1,          8'd59, 1'b0, NONE},
        '{OP_SHUFFLE, 10'd0,    31'h2AAAAAAA,   8'd1,  1'b0, NONE},
        '{OP_SHUFFLE, 10'd0,    31'h55555555,   8'd1,  1'b1, '{10'd0, 1'b0, 1'b1, 1'b0}},
        '{OP_SHUFFLE, 10'd0,    31'd12345,      8'd1,  1'b0, NONE},       // next pass at once
        '{OP_DRAW,    10'd0,    31'd0,          8'd3,  1'b0, NONE},
        '{OP_LOAD,    10'h155,  31'd0,          8'd1,  1'b1, '{10'd0, 1'b0, 1'b0, 1'b1}},
        '{OP_CLEAR,   10'd0,    31'd0,          8'd1,  1'b1, NONE},
        '{OP_DRAW,    10'd0,    31'd0,          8'd1,  1'b1, NONE},
        '{OP_SHUFFLE, 10'd0,    31'h7FFFFFFF,   8'd3,  1'b0, NONE},       // swap empty slots
        '{OP_LOAD,    10'h2AA,  31'd0,          8'd1,  1'b1, NONE},
        '{OP_LOAD,    10'h155,  31'd0,          8'd1,  1'b1, NONE},
        '{OP_DRAW,    10'd0,    31'd0,          8'd1,  1'b1, '{10'h2AA, 1'b1, 1'b0, 1'b0}},
        '{OP_DRAW,    10'd0,    31'd0,          8'd1,  1'b1, '{10'h155, 1'b1, 1'b0, 1'b0}},
        '{OP_DRAW,    10'd0,    31'd0,          8'd1,  1'b1, NONE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // [9:0] card_index, [40:10] random_word, rest zero
    logic [1:0]  s_axis_tuser;    // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;    // [9:0] drawn_card, rest zero
    logic [2:0]  m_axis_tuser;    // [0] card_found, [1] shuffle_done, [2] load_dropped

    // Predicted deck contents and pointers
    logic [CARD_W-1:0] deck_card [DECK_SLOTS];
    logic              deck_full [DECK_SLOTS];
    logic [LPOS_W-1:0] deck_load_pos;
    logic [SLOT_W-1:0] deck_shuffle_pos;

    deck_result_t pending_results [$];
    int           n_errors = 0;
    bit           steady_run = 1'b0;    // set to suspend idling on both sides

    shuffle_and_draw_deck u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Apply one operation to the predicted deck and return the result beat it causes.
    function automatic deck_result_t deck_apply(input t_op op, input logic [CARD_W-1:0] card,
                                                input logic [RND_W-1:0] rnd);
        deck_result_t      res;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] pick;
        logic [CARD_W-1:0] held_card;
        logic              held_full;
        res = NONE;
        case (op)
            OP_CLEAR: begin
                for (int k = 0; k < DECK_SLOTS; k++) deck_full[k] = 1'b0;
                deck_load_pos    = '0;
                deck_shuffle_pos = LAST_SLOT;
            end
            OP_LOAD: begin
                if (deck_load_pos < LOAD_END) begin
                    deck_card[deck_load_pos[SLOT_W-1:0]] = card;
                    deck_full[deck_load_pos[SLOT_W-1:0]] = 1'b1;
                    deck_load_pos++;
                end else begin
                    res.dropped = 1'b1;
                end
            end
            OP_SHUFFLE: begin
                pos = (deck_shuffle_pos == '0) ? LAST_SLOT : deck_shuffle_pos;
                pick = SLOT_W'(32'(rnd) % (32'(pos) + 32'd1));
                held_card = deck_card[pos];
                held_full = deck_full[pos];
                deck_card[pos]  = deck_card[pick];
                deck_full[pos]  = deck_full[pick];
                deck_card[pick] = held_card;
                deck_full[pick] = held_full;
                pos = pos - 1'b1;
                if (pos == '0) begin
                    res.done = 1'b1;
                    pos = LAST_SLOT;
                end
                deck_shuffle_pos = pos;
            end
            default: begin
                // take the lowest full slot
                for (int k = 0; k < DECK_SLOTS; k++) begin
                    if (deck_full[k] && !res.found) begin
                        deck_full[k] = 1'b0;
                        res.card     = deck_card[k];
                        res.found    = 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Present one beat, hold it until accepted, then queue its expected result.
    // Valid is left high on return so back-to-back beats need no second assignment.
    task automatic send_op(input t_op op, input logic [CARD_W-1:0] card,
                           input logic [RND_W-1:0] rnd, input logic typed,
                           input deck_result_t want);
        deck_result_t predicted;
        while (!steady_run && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, rnd, card};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = deck_apply(op, card, rnd);
        pending_results.push_back(typed ? want : predicted);
    endtask

    function automatic logic [RND_W-1:0] random_word();
        // favor small words now and then so low remainders show up often
        if ($urandom_range(0, 3) == 0) return RND_W'($urandom_range(0, 127));
        return RND_W'($urandom);
    endfunction

    // Sink side: stall at random, compare every accepted result beat in order.
    always @(posedge i_clk) begin : result_check
        deck_result_t seen;
        deck_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.card    = m_axis_tdata[CARD_W-1:0];
            seen.found   = m_axis_tuser[0];
            seen.done    = m_axis_tuser[1];
            seen.dropped = m_axis_tuser[2];
            if (pending_results.size() == 0) begin
                $error("result beat with none expected: %h", seen);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (seen.card !== want.card) begin
                    $error("drawn_card: expected %0d, got %0d", want.card, seen.card);
                    n_errors++;
                end
                if (seen.found !== want.found) begin
                    $error("card_found: expected %0b, got %0b", want.found, seen.found);
                    n_errors++;
                end
                if (seen.done !== want.done) begin
                    $error("shuffle_done: expected %0b, got %0b", want.done, seen.done);
                    n_errors++;
                end
                if (seen.dropped !== want.dropped) begin
                    $error("load_dropped: expected %0b, got %0b", want.dropped, seen.dropped);
                    n_errors++;
                end
            end
        end
        m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 24);
    end

    initial begin : stimulus
        int sent;
        int n_load;
        int n_shuffle;
        int n_draw;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_CLEAR;
        for (int k = 0; k < DECK_SLOTS; k++) begin
            deck_card[k] = '0;
            deck_full[k] = 1'b0;
        end
        deck_load_pos    = '0;
        deck_shuffle_pos = LAST_SLOT;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the fill rows write every slot before the first shuffle,
        // so no swap ever reads a card index that was never loaded.
        foreach (DIRECTED[r]) begin
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                send_op(DIRECTED[r].op, DIRECTED[r].card + CARD_W'(k),
                        DIRECTED[r].rnd + RND_W'(k), DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // Random episodes: mostly clear, load, shuffle, draw in order; the rest noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady_run = (sent >= 400 && sent < 550);
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_op(OP_CLEAR, CARD_W'($urandom), random_word(), 1'b0, NONE);
                    sent++;
                end
                n_load    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                        : $urandom_range(1, 12);
                n_shuffle = ($urandom_range(0, 7) == 0) ? $urandom_range(63, 130)
                                                        : $urandom_range(0, 8);
                n_draw    = $urandom_range(0, n_load + 2);
                repeat (n_load) send_op(OP_LOAD, CARD_W'($urandom_range(0, 1023)),
                                        random_word(), 1'b0, NONE);
                repeat (n_shuffle) send_op(OP_SHUFFLE, CARD_W'($urandom), random_word(),
                                           1'b0, NONE);
                repeat (n_draw) send_op(OP_DRAW, CARD_W'($urandom), random_word(), 1'b0, NONE);
                sent += n_load + n_shuffle + n_draw;
            end else begin
                n_load = $urandom_range(1, 6);
                repeat (n_load) send_op(t_op'($urandom_range(0, 3)), CARD_W'($urandom),
                                        random_word(), 1'b0, NONE);
                sent += n_load;
            end
        end
        steady_run = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, then give the block time to emit anything stray.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
